// ----- rtl/core/radius_calibration_interpolator_assert.svh -----
// Assertion macros shared by the checker of the radius calibration interpolator.
`ifndef RADIUS_CALIBRATION_INTERPOLATOR_ASSERT_SVH
`define RADIUS_CALIBRATION_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define RCI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define RCI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rci_pkg.sv -----
// Package with shared widths, codes and defaults of the radius calibration interpolator.
`default_nettype none
package rci_pkg;

  localparam int VAL_W          = 16;
  localparam int KIND_W         = 2;
  localparam int INDEX_W        = 6;
  localparam int FRAC_BITS      = 15;
  localparam int ONE            = 1 << FRAC_BITS;
  localparam int MUL_W          = 16;
  localparam int N_SEGMENTS_DEF = 12;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_LOAD = 2'd0;
  localparam kind_t KIND_FWD  = 2'd1;
  localparam kind_t KIND_INV  = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/core/rci_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rci_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 13,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/rci_table.sv -----
// Calibration table: RAM with per-entry valid bits that fall back to the reset ramp.
`default_nettype none
module rci_table #(
  parameter int N_SEGMENTS = rci_pkg::N_SEGMENTS_DEF,
  parameter int DEPTH      = N_SEGMENTS + 1,
  parameter int AW         = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [rci_pkg::VAL_W-1:0] wdata,
  input  wire logic [AW-1:0]            raddr,
  output logic      [rci_pkg::VAL_W-1:0] rdata,
  input  wire logic [AW-1:0]            ramp_addr,
  output logic      [rci_pkg::VAL_W-1:0] ramp_data
);
  import rci_pkg::*;

  logic [DEPTH-1:0] vld_r;
  logic             rd_vld_r;
  logic [AW-1:0]    raddr_r;
  logic [VAL_W-1:0] ram_q;
  logic [VAL_W-1:0] ramp_tab [DEPTH];

  // Reset contents: entry i is i/N rounded half up.
  for (genvar g = 0; g < DEPTH; g++) begin : g_ramp
    assign ramp_tab[g] = VAL_W'((g * ONE + N_SEGMENTS / 2) / N_SEGMENTS);
  end

  rci_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rd_vld_r <= vld_r[raddr];
    end
    raddr_r <= raddr;
  end

  assign rdata     = rd_vld_r ? ram_q : ramp_tab[raddr_r];
  assign ramp_data = ramp_tab[ramp_addr];

endmodule
`default_nettype wire

// ----- rtl/core/rci_mul.sv -----
// Shared unsigned multiplier with a registered product.
`default_nettype none
module rci_mul (
  input  wire logic                       clk,
  input  wire logic [rci_pkg::MUL_W-1:0]   a,
  input  wire logic [rci_pkg::MUL_W-1:0]   b,
  output logic      [2*rci_pkg::MUL_W-1:0] p_r
);
  import rci_pkg::*;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule
`default_nettype wire

// ----- rtl/core/radius_calibration_interpolator.sv -----
// Top level: sequencer and datapath of the radius calibration interpolator.
// Load items never raise busy. A forward item runs through S_F_MUL, S_F_SEG, S_F_RDLO,
// S_F_RDHI, S_F_M1 and S_F_M2 (it ends in S_F_SEG for a radius above 1.0); an inverse item
// runs S_I_RD0, S_I_CHK0, a search in S_I_SRCH (one table read a cycle), S_I_SEG, S_I_MA,
// S_I_MB and a 16-step divider, and ends early below entry 0, above every entry, or on a flat segment.
// busy stays high until the result cycle; rst_n (synchronous) restores the ramp via valid bits.
`default_nettype none
module radius_calibration_interpolator #(
  parameter int N_SEGMENTS = rci_pkg::N_SEGMENTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [rci_pkg::KIND_W-1:0]  in_kind,
  input  wire logic [rci_pkg::INDEX_W-1:0] in_index,
  input  wire logic [rci_pkg::VAL_W-1:0]   in_value,
  output logic                            out_valid,
  output logic      [rci_pkg::VAL_W-1:0]   out_result,
  output logic                            out_saturated
);
  import rci_pkg::*;

  localparam int DEPTH = N_SEGMENTS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = VAL_W + AW;
  localparam int DIVW  = VAL_W + AW;
  localparam int QW    = VAL_W;
  localparam int DW    = DIVW + FRAC_BITS + 1;
  localparam int RW    = DW - QW;
  localparam int ACCW  = 2 * VAL_W + 1;
  localparam int RESW  = ACCW - FRAC_BITS;
  localparam int CW    = $clog2(QW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_F_MUL, S_F_SEG, S_F_RDLO, S_F_RDHI, S_F_M1, S_F_M2,
    S_I_RD0, S_I_CHK0, S_I_SRCH, S_I_SEG, S_I_MA, S_I_MB, S_I_DIV
  } state_t;

  state_t            state_r, state_nxt;
  logic [VAL_W-1:0]  r_r, r_nxt;
  logic [AW-1:0]     seg_r, seg_nxt;
  logic [VAL_W-1:0]  d_r, d_nxt;
  logic [VAL_W-1:0]  lo_r, lo_nxt;
  logic [VAL_W-1:0]  hi_r, hi_nxt;
  logic [VAL_W-1:0]  den_r, den_nxt;
  logic [ACCW-1:0]   acc_r, acc_nxt;
  logic [DIVW-1:0]   a_r, a_nxt;
  logic [DIVW-1:0]   div_r, div_nxt;
  logic [RW-1:0]     rem_r, rem_nxt;
  logic [QW-1:0]     dq_r, dq_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_result_r, out_result_nxt;
  logic              out_sat_r, out_sat_nxt;

  logic              accept;
  logic              tbl_we;
  logic [AW-1:0]     tbl_raddr;
  logic [VAL_W-1:0]  tbl_rdata;
  logic [AW-1:0]     ramp_addr;
  logic [VAL_W-1:0]  ramp_data;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [2*MUL_W-1:0] prod_r;

  logic [PW-1:0]        p_val;
  logic [PW-FRAC_BITS-1:0] p_whole;
  logic [FRAC_BITS-1:0] p_frac;
  logic [AW-1:0]        seg_calc;
  logic [ACCW-1:0]      acc_sub;
  logic [RESW-1:0]      fwd_res;
  logic [DW-1:0]        dvd;
  logic [DW-1:0]        dvd_sum;
  logic [RW:0]          rem_sh;
  logic                 q_bit;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign tbl_we = accept && (in_kind == KIND_LOAD) && (in_index < INDEX_W'(DEPTH));

  rci_table #(
    .N_SEGMENTS (N_SEGMENTS),
    .DEPTH      (DEPTH),
    .AW         (AW)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .we        (tbl_we),
    .waddr     (in_index[AW-1:0]),
    .wdata     (in_value),
    .raddr     (tbl_raddr),
    .rdata     (tbl_rdata),
    .ramp_addr (ramp_addr),
    .ramp_data (ramp_data)
  );

  rci_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  // Segment of a forward radius: p = r*N, segment = ceil(p/ONE) but at least one,
  // and the offset inside the segment is the fraction, or ONE on an exact breakpoint above zero (0 at p = 0).
  assign p_val   = prod_r[PW-1:0];
  assign p_whole = p_val[PW-1:FRAC_BITS];
  assign p_frac  = p_val[FRAC_BITS-1:0];

  always_comb begin
    if (p_frac != '0) begin
      seg_calc = AW'(p_whole) + AW'(1);
    end else if (p_whole == '0) begin
      seg_calc = AW'(1);
    end else begin
      seg_calc = AW'(p_whole);
    end
  end

  assign acc_sub = acc_r - ACCW'(prod_r);
  assign fwd_res = acc_sub[ACCW-1:FRAC_BITS];
  assign dvd     = {a_r, {FRAC_BITS{1'b0}}, 1'b0} >> 1;
  assign dvd_sum = dvd + DW'(prod_r[DIVW-1:1]);
  assign rem_sh  = {rem_r, dq_r[QW-1]};
  assign q_bit   = (rem_sh >= {1'b0, div_r});

  always_comb begin
    state_nxt      = state_r;
    r_nxt          = r_r;
    seg_nxt        = seg_r;
    d_nxt          = d_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    den_nxt        = den_r;
    acc_nxt        = acc_r;
    a_nxt          = a_r;
    div_nxt        = div_r;
    rem_nxt        = rem_r;
    dq_nxt         = dq_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    out_sat_nxt    = out_sat_r;
    tbl_raddr      = '0;
    ramp_addr      = '0;
    mul_a          = '0;
    mul_b          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          r_nxt = in_value;
          if (in_kind == KIND_FWD) begin
            state_nxt = S_F_MUL;
          end else if (in_kind == KIND_INV) begin
            state_nxt = S_I_RD0;
          end
        end
      end
      S_F_MUL: begin
        mul_a     = r_r;
        mul_b     = MUL_W'(N_SEGMENTS);
        state_nxt = S_F_SEG;
      end
      S_F_SEG: begin
        if (p_val > PW'(N_SEGMENTS * ONE)) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = VAL_W'(ONE);
          out_sat_nxt    = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          seg_nxt   = seg_calc;
          d_nxt     = (p_frac != '0) ? VAL_W'(p_frac) :
                      ((p_whole == '0) ? '0 : VAL_W'(ONE));
          tbl_raddr = seg_calc - AW'(1);
          state_nxt = S_F_RDLO;
        end
      end
      S_F_RDLO: begin
        lo_nxt    = tbl_rdata;
        tbl_raddr = seg_r;
        state_nxt = S_F_RDHI;
      end
      S_F_RDHI: begin
        hi_nxt    = tbl_rdata;
        mul_a     = d_r;
        mul_b     = tbl_rdata;
        state_nxt = S_F_M1;
      end
      S_F_M1: begin
        // lo*ONE + d*hi - d*lo equals (ONE-d)*lo + d*hi and never goes negative.
        acc_nxt   = (ACCW'(lo_r) << FRAC_BITS) + ACCW'(prod_r) + ACCW'(ONE / 2);
        mul_a     = d_r;
        mul_b     = lo_r;
        state_nxt = S_F_M2;
      end
      S_F_M2: begin
        acc_nxt       = acc_sub;
        out_valid_nxt = 1'b1;
        if (fwd_res > RESW'(ONE)) begin
          out_result_nxt = VAL_W'(ONE);
          out_sat_nxt    = 1'b1;
        end else begin
          out_result_nxt = fwd_res[VAL_W-1:0];
          out_sat_nxt    = 1'b0;
        end
        state_nxt = S_IDLE;
      end
      S_I_RD0: begin
        tbl_raddr = '0;
        state_nxt = S_I_CHK0;
      end
      S_I_CHK0: begin
        if (r_r < tbl_rdata) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = '0;
          out_sat_nxt    = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          lo_nxt    = tbl_rdata;
          seg_nxt   = AW'(1);
          tbl_raddr = AW'(1);
          state_nxt = S_I_SRCH;
        end
      end
      S_I_SRCH: begin
        if (r_r <= tbl_rdata) begin
          hi_nxt    = tbl_rdata;
          state_nxt = S_I_SEG;
        end else if (seg_r == AW'(N_SEGMENTS)) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = VAL_W'(ONE);
          out_sat_nxt    = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          lo_nxt    = tbl_rdata;
          seg_nxt   = seg_r + AW'(1);
          tbl_raddr = seg_r + AW'(1);
        end
      end
      S_I_SEG: begin
        ramp_addr = seg_r - AW'(1);
        if (hi_r <= lo_r || r_r < lo_r) begin
          // A flat or falling segment maps to its lower breakpoint.
          out_valid_nxt  = 1'b1;
          out_result_nxt = ramp_data;
          out_sat_nxt    = 1'b0;
          state_nxt      = S_IDLE;
        end else begin
          den_nxt   = hi_r - lo_r;
          mul_a     = MUL_W'(seg_r - AW'(1));
          mul_b     = hi_r - lo_r;
          state_nxt = S_I_MA;
        end
      end
      S_I_MA: begin
        a_nxt     = DIVW'(prod_r) + DIVW'(r_r - lo_r);
        mul_a     = MUL_W'(N_SEGMENTS);
        mul_b     = den_r;
        state_nxt = S_I_MB;
      end
      S_I_MB: begin
        // Dividend a*ONE + div/2; the quotient fits in QW bits, so its top part
        // already lies below the divisor.
        div_nxt   = prod_r[DIVW-1:0];
        rem_nxt   = dvd_sum[DW-1:QW];
        dq_nxt    = dvd_sum[QW-1:0];
        cnt_nxt   = CW'(QW);
        state_nxt = S_I_DIV;
      end
      S_I_DIV: begin
        rem_nxt = q_bit ? RW'(rem_sh - {1'b0, div_r}) : rem_sh[RW-1:0];
        dq_nxt  = {dq_r[QW-2:0], q_bit};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          out_valid_nxt = 1'b1;
          if ({dq_r[QW-2:0], q_bit} > QW'(ONE)) begin
            out_result_nxt = VAL_W'(ONE);
            out_sat_nxt    = 1'b1;
          end else begin
            out_result_nxt = {dq_r[QW-2:0], q_bit};
            out_sat_nxt    = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    r_r          <= r_nxt;
    seg_r        <= seg_nxt;
    d_r          <= d_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    den_r        <= den_nxt;
    acc_r        <= acc_nxt;
    a_r          <= a_nxt;
    div_r        <= div_nxt;
    rem_r        <= rem_nxt;
    dq_r         <= dq_nxt;
    cnt_r        <= cnt_nxt;
    out_result_r <= out_result_nxt;
    out_sat_r    <= out_sat_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_result    = out_result_r;
  assign out_saturated = out_sat_r;

endmodule
`default_nettype wire

// ----- rtl/core/rci_checker.sv -----
// Port-level checker of the radius calibration interpolator and its bind.
`default_nettype none
`include "radius_calibration_interpolator_assert.svh"
module rci_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic [rci_pkg::KIND_W-1:0]  in_kind,
  input wire logic                       out_valid,
  input wire logic [rci_pkg::VAL_W-1:0]   out_result,
  input wire logic                       out_saturated
);
  import rci_pkg::*;

  logic map_xfer;
  logic quiet_xfer;
  logic sat_res;
  logic clamped;

  assign map_xfer   = start && !busy && (in_kind == KIND_FWD || in_kind == KIND_INV);
  assign quiet_xfer = start && !busy && !(in_kind == KIND_FWD || in_kind == KIND_INV);
  assign sat_res    = out_valid && out_saturated;
  assign clamped    = (out_result == VAL_W'(ONE)) || (out_result == '0);

  `RCI_ASSERT_NOW(a_result_range, out_valid, out_result <= VAL_W'(ONE), "result above 1.0")
  `RCI_ASSERT_NOW(a_sat_clamped, sat_res, clamped, "saturated result not clamped")
  `RCI_ASSERT_NOW(a_result_idle, out_valid, !busy, "result strobe while still busy")
  `RCI_ASSERT_NEXT(a_map_busy, map_xfer, busy && !out_valid, "mapping transfer left busy low")
  `RCI_ASSERT_NEXT(a_load_quiet, quiet_xfer, !busy && !out_valid, "load or no-op caused activity")

endmodule

bind radius_calibration_interpolator rci_checker u_rci_checker (.*);
`default_nettype wire
